// ===== design/gpwc_pkg.sv =====
// shared types and constants for the gated photon window counter
package gpwc_pkg;

  typedef enum logic [1:0] {
    KIND_EVENT  = 2'd0,
    KIND_MARKER = 2'd1,
    KIND_FINISH = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    RES_OTHER   = 4'd0,
    RES_MARKER  = 4'd1,
    RES_STORED  = 4'd2,
    RES_DROPPED = 4'd3,
    RES_OPENED  = 4'd4,
    RES_BAD     = 4'd5,
    RES_PULSE   = 4'd6,
    RES_GROUP   = 4'd7,
    RES_SURPLUS = 4'd8,
    RES_FINISH  = 4'd9
  } res_e;

  localparam logic [2:0] REG_PHOTON_CHAN    = 3'd0;
  localparam logic [2:0] REG_TRIGGER_CHAN   = 3'd1;
  localparam logic [2:0] REG_REPEATS        = 3'd2;
  localparam logic [2:0] REG_EXPECTED_TOTAL = 3'd3;
  localparam logic [2:0] REG_FRAME_TICKS    = 3'd4;

  localparam logic [15:0] DefaultRepeats = 16'd1000;
  localparam int          TimeW          = 48;

  // one item as it travels from the front to the back
  typedef struct packed {
    kind_e       kind;
    logic [1:0]  chan;
    logic [26:0] tag_time;
  } item_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] a);
    sat_inc = (a == 32'hFFFF_FFFF) ? a : a + 32'd1;
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

// ===== design/gpwc_front.sv =====
// input skid queue: accepts items and holds them until the back takes them
module gpwc_front
  import gpwc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  item_t in_item_i,
  output logic  q_valid_o,
  input  logic  q_take_i,
  output item_t q_item_o
);
  item_t      slot_q [2];
  logic       wr_q, rd_q, wr_d, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_valid_o && q_take_i;
  assign q_item_o   = slot_q[rd_q];

  always_comb begin
    wr_d  = push ? !wr_q : wr_q;
    rd_d  = pop ? !rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_q] <= in_item_i;
  end
endmodule

// ===== design/gated_photon_window_counter.sv =====
// top level of the gated photon window counter: front queue and sequenced back end
// Time-tag events, frame markers and finish commands enter through a two-entry
// queue and are then processed one at a time by a sequencer. From the head of the
// queue to the result register a marker, a finish or an ignored item passes through
// check only, and any event through check, frame lift and action. A backwards
// trigger time repeats the frame lift for each inferred frame (up to GUARD_LIMIT).
// Closing a window adds a read and a pop state, and both again per photon popped,
// set by the single registered read port of the photon memory. Each item yields
// one result held in an output register until it is transferred; a stalled
// result holds the sequencer in its last state.
module gated_photon_window_counter
  import gpwc_pkg::*;
#(
  parameter int FIFO_DEPTH  = 4096,
  parameter int CHANNELS    = 4,
  parameter int GUARD_LIMIT = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [26:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [1:0]  chan_i,
  input  logic [26:0] tag_time_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  event_res_o,
  output logic [15:0] group_number_o,
  output logic [31:0] even_total_o,
  output logic [31:0] odd_total_o,
  output logic [12:0] window_photons_o,
  output logic [31:0] frame_number_o,
  output logic [31:0] extra_frames_o,
  output logic [31:0] skipped_windows_o,
  output logic [12:0] photon_fill_o,
  output logic [31:0] pulses_done_o
);
  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int FW = AW + 1;
  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int GW = $clog2(GUARD_LIMIT + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_GUARD = 7'b0000100,
    S_ACT   = 7'b0001000,
    S_READ  = 7'b0010000,
    S_POP   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  // configuration
  logic [1:0]  photon_chan_q, trigger_chan_q;
  logic [15:0] repeats_q, expected_q;
  logic [26:0] frame_ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      photon_chan_q  <= 2'd0;
      trigger_chan_q <= 2'd1;
      repeats_q      <= 16'd1000;
      expected_q     <= 16'd0;
      frame_ticks_q  <= 27'd100000000;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_PHOTON_CHAN:    photon_chan_q  <= cfg_data_i[1:0];
        REG_TRIGGER_CHAN:   trigger_chan_q <= cfg_data_i[1:0];
        REG_REPEATS:        repeats_q      <= cfg_data_i[15:0];
        REG_EXPECTED_TOTAL: expected_q     <= cfg_data_i[15:0];
        REG_FRAME_TICKS:    frame_ticks_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front queue
  item_t in_item, it;
  logic  q_valid, q_take;
  assign in_item = '{kind: kind_e'(kind_i), chan: chan_i, tag_time: tag_time_i};

  gpwc_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .in_item_i(in_item),
    .q_valid_o(q_valid), .q_take_i(q_take), .q_item_o(it)
  );

  // back-end state
  state_e      state_q;
  logic [31:0] frame_count_q, implicit_q, bad_q, pulses_q, even_q, odd_q;
  logic [47:0] frame_base_q, window_start_q, t_q, rd_data_q;
  logic [26:0] last_time_q [CHANNELS];
  logic [CHANNELS-1:0] last_valid_q;
  logic        start_pending_q;
  logic [AW-1:0] head_q;
  logic [FW-1:0] fill_q;
  logic [16:0] slot_q;
  logic [15:0] groups_q;
  logic [GW-1:0] guard_q;
  logic [12:0] wph_q;
  logic [47:0] fifo_mem [FIFO_DEPTH];
  logic        out_valid_q;
  logic [3:0]  res_q;
  logic [15:0] gnum_q;
  logic [31:0] ev_q, od_q;

  logic        chan_ok;
  logic [CW-1:0] cidx;
  logic [47:0] t_now;
  logic [17:0] two_rep;
  logic [15:0] rep;
  logic        out_free;

  assign chan_ok  = ({30'd0, it.chan} < CHANNELS[31:0]);
  assign cidx     = CW'(it.chan);
  assign t_now    = frame_base_q + {21'd0, it.tag_time};
  assign rep      = (repeats_q == 16'd0) ? DefaultRepeats : repeats_q;
  assign two_rep  = {1'b0, rep, 1'b0};
  assign out_free = !out_valid_q || !out_stall_i;
  assign q_take   = (state_q == S_DONE) && out_free;

  logic [AW-1:0] wr_addr;
  logic [FW-1:0] wsum;
  assign wsum    = {1'b0, head_q} + fill_q;
  assign wr_addr = wsum[AW-1:0];

  // photon memory, one write and one registered read port
  logic mem_we;
  assign mem_we = (state_q == S_ACT) && (it.chan == photon_chan_q)
                  && (fill_q < FIFO_DEPTH[FW-1:0]);
  always_ff @(posedge clk_i) begin
    if (mem_we) fifo_mem[wr_addr] <= t_q;
    rd_data_q <= fifo_mem[head_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      frame_count_q   <= '0;
      frame_base_q    <= '0;
      last_valid_q    <= '0;
      start_pending_q <= 1'b0;
      head_q          <= '0;
      fill_q          <= '0;
      slot_q          <= '0;
      even_q          <= '0;
      odd_q           <= '0;
      groups_q        <= '0;
      implicit_q      <= '0;
      bad_q           <= '0;
      pulses_q        <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      // result register fills on hand-over and empties on transfer
      if (q_take) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (q_valid) begin
            res_q   <= RES_OTHER;
            gnum_q  <= '0;
            wph_q   <= '0;
            guard_q <= '0;
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (it.kind == KIND_MARKER && chan_ok) begin
            frame_count_q      <= frame_count_q + 32'd1;
            frame_base_q       <= frame_base_q + {21'd0, frame_ticks_q};
            last_valid_q[cidx] <= 1'b0;
            res_q              <= RES_MARKER;
            state_q            <= S_DONE;
          end else if (it.kind == KIND_FINISH) begin
            start_pending_q <= 1'b0;
            res_q           <= RES_FINISH;
            state_q         <= S_DONE;
          end else if (it.kind == KIND_EVENT && chan_ok) begin
            if (last_valid_q[cidx] && it.tag_time < last_time_q[cidx]) begin
              frame_count_q <= frame_count_q + 32'd1;
              frame_base_q  <= frame_base_q + {21'd0, frame_ticks_q};
              implicit_q    <= sat_inc(implicit_q);
            end
            state_q <= S_GUARD;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_GUARD: begin
          // lift a backwards trigger time one frame per pass
          t_q <= t_now;
          if (it.chan == trigger_chan_q && start_pending_q && t_now <= window_start_q
              && guard_q < GUARD_LIMIT[GW-1:0]) begin
            frame_count_q <= frame_count_q + 32'd1;
            frame_base_q  <= frame_base_q + {21'd0, frame_ticks_q};
            implicit_q    <= sat_inc(implicit_q);
            guard_q       <= guard_q + GW'(1);
          end else begin
            state_q <= S_ACT;
          end
        end
        S_ACT: begin
          last_time_q[cidx]  <= it.tag_time;
          last_valid_q[cidx] <= 1'b1;
          if (it.chan == photon_chan_q) begin
            state_q <= S_DONE;
            if (fill_q < FIFO_DEPTH[FW-1:0]) begin
              fill_q <= fill_q + FW'(1);
              res_q  <= RES_STORED;
            end else begin
              res_q  <= RES_DROPPED;
            end
          end else if (it.chan == trigger_chan_q) begin
            if (!start_pending_q) begin
              window_start_q  <= t_q;
              start_pending_q <= 1'b1;
              res_q           <= RES_OPENED;
              state_q         <= S_DONE;
            end else if (t_q <= window_start_q) begin
              bad_q           <= sat_inc(bad_q);
              start_pending_q <= 1'b0;
              res_q           <= RES_BAD;
              state_q         <= S_DONE;
            end else begin
              state_q <= S_READ;
            end
          end else begin
            state_q <= S_DONE;
          end
        end
        S_READ: state_q <= S_POP;  // head entry read latency
        S_POP: begin
          if (fill_q != '0 && rd_data_q < t_q) begin
            if (rd_data_q >= window_start_q) wph_q <= wph_q + 13'd1;
            head_q  <= head_q + AW'(1);
            fill_q  <= fill_q - FW'(1);
            state_q <= S_READ;
          end else begin
            start_pending_q <= 1'b0;
            pulses_q        <= sat_inc(pulses_q);
            state_q         <= S_DONE;
            if ({slot_q + 17'd1} >= two_rep[16:0] || two_rep[17]) begin
              ev_q   <= slot_q[0] ? even_q : sat_add(even_q, {19'd0, wph_q});
              od_q   <= slot_q[0] ? sat_add(odd_q, {19'd0, wph_q}) : odd_q;
              even_q <= '0;
              odd_q  <= '0;
              slot_q <= '0;
              if (expected_q == 16'd0 || groups_q < expected_q) begin
                gnum_q   <= groups_q;
                groups_q <= groups_q + 16'd1;
                res_q    <= RES_GROUP;
              end else begin
                res_q <= RES_SURPLUS;
              end
            end else begin
              res_q  <= RES_PULSE;
              slot_q <= slot_q + 17'd1;
              if (slot_q[0]) odd_q <= sat_add(odd_q, {19'd0, wph_q});
              else even_q <= sat_add(even_q, {19'd0, wph_q});
            end
          end
        end
        S_DONE: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  logic shown;
  assign shown = (res_q == RES_GROUP) || (res_q == RES_SURPLUS);

  // output register: snapshot of counters at hand-over
  logic [31:0] ev_o_q, od_o_q, fc_o_q, im_o_q, bd_o_q, pd_o_q;
  logic [12:0] wph_o_q, fill_o_q;
  logic [3:0]  res_o_q;
  logic [15:0] gnum_o_q;
  always_ff @(posedge clk_i) begin
    if (q_take) begin
      res_o_q  <= res_q;
      gnum_o_q <= gnum_q;
      ev_o_q   <= shown ? ev_q : even_q;
      od_o_q   <= shown ? od_q : odd_q;
      wph_o_q  <= wph_q;
      fc_o_q   <= frame_count_q;
      im_o_q   <= implicit_q;
      bd_o_q   <= bad_q;
      fill_o_q <= 13'(fill_q);
      pd_o_q   <= pulses_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign event_res_o       = res_o_q;
  assign group_number_o    = gnum_o_q;
  assign even_total_o      = ev_o_q;
  assign odd_total_o       = od_o_q;
  assign window_photons_o  = wph_o_q;
  assign frame_number_o    = fc_o_q;
  assign extra_frames_o    = im_o_q;
  assign skipped_windows_o = bd_o_q;
  assign photon_fill_o     = fill_o_q;
  assign pulses_done_o     = pd_o_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FIFO_DEPTH[FW-1:0]) else $error("photon fill beyond depth");
  a_take_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_take |=> out_valid_q) else $error("result lost after item taken");
  a_group_num: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && event_res_o != RES_GROUP) |-> group_number_o == 16'd0)
    else $error("group number on non-group result");
`endif
endmodule
